// ===== hdl/mqlb_pkg.sv =====
// Shared constants, types and helper functions for the multi-queue linked buffer.
package mqlb_pkg;

   // Pool and queue sizing.
   localparam int SLOT_COUNT  = 64;
   localparam int QUEUE_COUNT = 8;

   // Slot pointers carry one extra code past the last slot, which means null.
   localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
   localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

   // Fixed field widths of the channels.
   localparam int QID_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef logic [SLOT_W-1:0] slot_type;
   localparam slot_type NIL_SLOT = slot_type'(SLOT_COUNT);

   // Operation codes of a request item.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_LINK,
      S_TAIL,
      S_DONE
   } state_type;

   // Write request into the queue head and tail table.
   typedef struct packed {
      logic              head_we;
      logic              tail_we;
      logic [QIDX_W-1:0] qidx;
      slot_type          head;
      slot_type          tail;
   } qt_write_type;

   // A pointer names a real slot only below the slot count.
   function automatic logic slot_ok(slot_type s);
      return s < NIL_SLOT;
   endfunction

   // A queue id is usable only below the queue count.
   function automatic logic qid_ok(logic [QID_W-1:0] q);
      return 32'(q) < QUEUE_COUNT;
   endfunction

   // Table index of a queue id.
   function automatic logic [QIDX_W-1:0] qid_index(logic [QID_W-1:0] q);
      return QIDX_W'(q);
   endfunction

   // Memory index of a slot pointer that is known to be in range.
   function automatic logic [IDX_W-1:0] slot_index(slot_type s);
      return s[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/mqlb_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface mqlb_req_if;
   import mqlb_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [QID_W-1:0]         queue_id;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output queue_id, output value, input ready);
   modport sink   (input valid, input op, input queue_id, input value, output ready);
endinterface

interface mqlb_rsp_if;
   import mqlb_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data;

   modport source (output valid, output status, output data, input ready);
   modport sink   (input valid, input status, input data, output ready);
endinterface

// ===== hdl/mqlb_queue_table.sv =====
// Head and tail pointer table of all queues, read at one queue and written at one queue.
module mqlb_queue_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mqlb_pkg::QIDX_W-1:0]   rd_qidx,
   output mqlb_pkg::slot_type            head_rd,
   output mqlb_pkg::slot_type            tail_rd,
   input  mqlb_pkg::qt_write_type        wr
);
   import mqlb_pkg::*;

   slot_type head_ff [QUEUE_COUNT];
   slot_type tail_ff [QUEUE_COUNT];

   // Read port for the queue under work.
   assign head_rd = head_ff[rd_qidx];
   assign tail_rd = tail_ff[rd_qidx];

   // All queues start empty; head and tail are written independently.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            head_ff[i] <= NIL_SLOT;
            tail_ff[i] <= NIL_SLOT;
         end
      end else begin
         if (wr.head_we) begin
            head_ff[wr.qidx] <= wr.head;
         end
         if (wr.tail_we) begin
            tail_ff[wr.qidx] <= wr.tail;
         end
      end
   end

endmodule

// ===== hdl/multi_queue_linked_buffer.sv =====
// Top level: several FIFO queues kept as linked lists over one shared slot pool.
// Steps: an item is accepted in the idle state; a refused request goes from the read step to
// the done step, a dequeue or an enqueue into an empty queue passes the link step, and an
// enqueue into a non-empty queue also the tail step; the result is registered in the done step,
// which waits while the result register holds an untaken item; then a new item is accepted.
// The link memory gets one read and up to two writes per item, a step each.
// Reset: synchronous; then the pool is chained into the free list while no item is accepted.
module multi_queue_linked_buffer (
   input logic       clock,
   input logic       reset,
   mqlb_req_if.sink  req_chan,
   mqlb_rsp_if.source rsp_chan
);
   import mqlb_pkg::*;

   // Sequencer and control registers.
   state_type state_ff, state_in;
   slot_type  init_cnt_ff, init_cnt_in;
   slot_type  free_head_ff, free_head_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Item and working registers.
   logic                     op_ff;
   logic [QID_W-1:0]         qid_ff;
   logic signed [DATA_W-1:0] val_ff;
   slot_type                 slot_ff, slot_in;
   slot_type                 tail_ff, tail_in;
   logic                     head_null_ff, head_null_in;
   status_type               res_status_ff, res_status_in;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;

   // Memories and their ports.
   slot_type                 link_mem [SLOT_COUNT];
   logic signed [DATA_W-1:0] data_mem [SLOT_COUNT];
   slot_type                 link_rd_ff;
   logic signed [DATA_W-1:0] data_rd_ff;
   logic                     link_we;
   logic [IDX_W-1:0]         link_wa;
   slot_type                 link_wd;
   logic [IDX_W-1:0]         link_ra;
   logic                     data_we;
   logic [IDX_W-1:0]         data_addr;

   // Queue table.
   slot_type     head_rd;
   slot_type     tail_rd;
   qt_write_type qt_wr;

   logic req_accept;
   logic rsp_load;

   mqlb_queue_table u_queue_table (
      .clock   (clock),
      .reset   (reset),
      .rd_qidx (qid_index(qid_ff)),
      .head_rd (head_rd),
      .tail_rd (tail_rd),
      .wr      (qt_wr)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_chan.op;
         qid_ff <= req_chan.queue_id;
         val_ff <= req_chan.value;
      end
      slot_ff       <= slot_in;
      tail_ff       <= tail_in;
      head_null_ff  <= head_null_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   // Link memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   // Data memory: written on enqueue, read on dequeue.
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_addr] <= val_ff;
      end
      data_rd_ff <= data_mem[data_addr];
   end

   // Sequencer: next state, memory ports and table writes.
   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      free_head_in  = free_head_ff;
      rsp_valid_in  = rsp_valid_ff;
      slot_in       = slot_ff;
      tail_in       = tail_ff;
      head_null_in  = head_null_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_load      = 1'b0;
      link_we       = 1'b0;
      link_wa       = slot_index(slot_ff);
      link_wd       = NIL_SLOT;
      link_ra       = slot_index(slot_ff);
      data_we       = 1'b0;
      data_addr     = slot_index(slot_ff);
      qt_wr         = '{head_we: 1'b0, tail_we: 1'b0, qidx: qid_index(qid_ff),
                        head: slot_ff, tail: slot_ff};

      // The result register empties when the sink takes the item.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            // Chain slot i to slot i+1; the last slot points at null.
            link_we     = 1'b1;
            link_wa     = slot_index(init_cnt_ff);
            link_wd     = init_cnt_ff + slot_type'(1);
            init_cnt_in = init_cnt_ff + slot_type'(1);
            if (init_cnt_ff == slot_type'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Pick the slot, check the request, and start the link read.
            tail_in      = tail_rd;
            head_null_in = !slot_ok(head_rd);
            if (op_ff == OP_ENQUEUE) begin
               slot_in       = free_head_ff;
               res_data_in   = '0;
               link_ra       = slot_index(free_head_ff);
               data_addr     = slot_index(free_head_ff);
               if (qid_ok(qid_ff) && slot_ok(free_head_ff)) begin
                  data_we       = 1'b1;
                  res_status_in = ST_OK;
                  state_in      = S_LINK;
               end else begin
                  res_status_in = ST_OVERFLOW;
                  state_in      = S_DONE;
               end
            end else begin
               slot_in   = head_rd;
               link_ra   = slot_index(head_rd);
               data_addr = slot_index(head_rd);
               if (qid_ok(qid_ff) && slot_ok(head_rd)) begin
                  res_status_in = ST_OK;
                  state_in      = S_LINK;
               end else begin
                  res_status_in = ST_UNDERFLOW;
                  res_data_in   = '1;
                  state_in      = S_DONE;
               end
            end
         end
         S_LINK: begin
            link_we = 1'b1;
            link_wa = slot_index(slot_ff);
            if (op_ff == OP_ENQUEUE) begin
               // Pop the free list; the new slot ends its queue.
               free_head_in  = link_rd_ff;
               link_wd       = NIL_SLOT;
               qt_wr.head_we = head_null_ff;
               qt_wr.tail_we = 1'b1;
               if (!head_null_ff && slot_ok(tail_ff)) begin
                  state_in = S_TAIL;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               // Unlink the head slot and push it onto the free list.
               qt_wr.head_we = 1'b1;
               qt_wr.head    = link_rd_ff;
               link_wd       = free_head_ff;
               free_head_in  = slot_ff;
               res_data_in   = data_rd_ff;
               state_in      = S_DONE;
            end
         end
         S_TAIL: begin
            // Link the old tail to the new slot.
            link_we  = 1'b1;
            link_wa  = slot_index(tail_ff);
            link_wd  = slot_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // The free head is always a slot or null once the pool is chained.
   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |-> (free_head_ff <= NIL_SLOT))
      else $error("free list head out of range");

   // An accepted item always goes straight to the read step.
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_READ))
      else $error("accepted item did not start");

   // Only an enqueue into a non-empty queue reaches the tail link step.
   a_tail_after_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL) |-> ($past(state_ff) == S_LINK && op_ff == OP_ENQUEUE
                                && !head_null_ff))
      else $error("tail link step out of sequence");

   // An underflow result always carries all ones.
   a_underflow_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == ST_UNDERFLOW) |-> (res_data_ff == '1))
      else $error("underflow result without all-ones data");

endmodule
